/* rtl/zero_cell_neighbor_average_fill_defines.svh */
// Assertion macros shared by the zero-cell fill block.
`ifndef ZERO_CELL_NEIGHBOR_AVERAGE_FILL_DEFINES_SVH
`define ZERO_CELL_NEIGHBOR_AVERAGE_FILL_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define ZCNAF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated off during reset.
`define ZCNAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/zcnaf_pkg.sv */
// Types and constants shared by the zero-cell fill controller and datapath.
package zcnaf_pkg;

	localparam int DEF_MAX_COLUMNS = 1024;
	localparam int DEF_PIXEL_BITS  = 16;

	localparam int FIELD_BITS     = 16;
	localparam int COLS_REG_BITS  = 11;
	localparam int ROWS_REG_BITS  = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [COLS_REG_BITS-1:0] COLS_RESET = 11'd1024;
	localparam logic [ROWS_REG_BITS-1:0] ROWS_RESET = 16'd1;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT    = 1'b1;

	// item commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_SUM,
		ST_MUL,
		ST_LOAD
	} zcnaf_state_t;

	// ring reads, in issue order
	typedef enum logic [1:0] {
		NB_RIGHT,
		NB_CENTRE,
		NB_LEFT,
		NB_UP
	} zcnaf_nbr_t;

	typedef struct packed {
		logic       accept;
		logic       rd_en;
		zcnaf_nbr_t rd_sel;
		logic       sum_en;
		logic       mul_en;
		logic       load_out;
	} zcnaf_cmd_t;

	typedef struct packed {
		logic emit;
		logic out_free;
	} zcnaf_status_t;

endpackage

/* rtl/zcnaf_ctrl.sv */
// Sequencer: takes an item, walks the ring reads, sum, divide and output load.
`include "zero_cell_neighbor_average_fill_defines.svh"

module zcnaf_ctrl import zcnaf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  zcnaf_status_t status,
	output zcnaf_cmd_t    cmd
);

	zcnaf_state_t state_q, state_d;
	logic [1:0]   rd_cnt_q, rd_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
		end else begin
			state_q  <= state_d;
			rd_cnt_q <= rd_cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_cnt_d   = rd_cnt_q;
		in_stall   = 1'b1;
		cmd        = '0;
		cmd.rd_sel = NB_RIGHT;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.emit) begin
						state_d  = ST_READ;
						rd_cnt_d = '0;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = zcnaf_nbr_t'(rd_cnt_q);
				rd_cnt_d   = rd_cnt_q + 2'd1;
				if (zcnaf_nbr_t'(rd_cnt_q) == NB_UP) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				// last ring word lands in the neighbor regs this cycle
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ZCNAF_ASSERT_NEXT(a_emit_starts_read, clk, arst_n, (cmd.accept && status.emit), (state_q == ST_READ && zcnaf_nbr_t'(rd_cnt_q) == NB_RIGHT), "result item did not start ring reads")
	`ZCNAF_ASSERT_NEXT(a_load_returns_idle, clk, arst_n, (state_q == ST_LOAD && status.out_free), (state_q == ST_IDLE && !in_stall), "sequencer did not reopen input after load")

endmodule

/* rtl/zcnaf_dp.sv */
// Datapath: config regs, history ring, position counters, average and output register.
`include "zero_cell_neighbor_average_fill_defines.svh"

module zcnaf_dp import zcnaf_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      command,
	input  logic [FIELD_BITS-1:0]     pixel_in,
	input  zcnaf_cmd_t                cmd,
	output zcnaf_status_t             status,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [FIELD_BITS-1:0]     pixel_out,
	output logic                      was_filled,
	output logic                      end_of_row,
	output logic                      end_of_frame
);

	localparam int DEPTH = 2 * MAX_COLUMNS + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int AW1   = AW + 1;
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int XW    = $clog2(MAX_COLUMNS);
	localparam int FW    = $clog2(MAX_COLUMNS + 2);
	localparam int SW    = PIXEL_BITS + 2;
	localparam int K     = PIXEL_BITS + 3;
	localparam int RW    = K + 1;
	localparam int PW    = SW + RW;
	localparam int EXW   = PIXEL_BITS + FIELD_BITS;
	localparam int INW   = FIELD_BITS + 32;

	localparam logic [63:0]   ONE64 = 64'd1;
	localparam logic [RW-1:0] RCP1  = RW'(ONE64 << K);
	localparam logic [RW-1:0] RCP2  = RW'(ONE64 << (K - 1));
	localparam logic [RW-1:0] RCP3  = RW'(((ONE64 << K) + 64'd2) / 64'd3);
	localparam logic [RW-1:0] RCP4  = RW'(ONE64 << (K - 2));

	// config
	logic [COLS_REG_BITS-1:0] column_count_q;
	logic [ROWS_REG_BITS-1:0] row_count_q;
	logic [CW-1:0]            cols_w;
	logic [ROWS_REG_BITS-1:0] rows_w;

	// stream position and ring bookkeeping
	logic [AW-1:0]         wp_q, cur_q;
	logic [NW-1:0]         wcnt_q;
	logic [XW-1:0]         col_q;
	logic [15:0]           row_q;
	logic [FW-1:0]         fill_q;
	logic [PIXEL_BITS-1:0] prev_q;
	logic [CW-1:0]         cols_q;
	logic                  top_q, left_edge_q, last_col_q, last_row_q;
	logic                  last_col_w, last_row_w;
	logic [INW-1:0]        pix_ext;
	logic [PIXEL_BITS-1:0] pix_v;

	// ring read path
	logic [PIXEL_BITS-1:0] ring_mem [DEPTH];
	logic [AW-1:0]         rd_off, rd_addr;
	logic                  rd_ok;
	logic                  rd_en_s1, rd_ok_s1;
	zcnaf_nbr_t            rd_sel_s1;
	logic [PIXEL_BITS-1:0] rd_data_s1, rd_val;

	// neighbors and arithmetic
	logic [PIXEL_BITS-1:0] up_q, down_q, left_q, right_q, centre_q;
	logic [SW-1:0]         sum_q;
	logic [2:0]            nz_q;
	logic [RW-1:0]         rcp_w;
	logic [PW-1:0]         prod_q;
	logic [PIXEL_BITS-1:0] quot_w, res_w;
	logic [EXW-1:0]        res_ext;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COLS_RESET;
			row_count_q    <= ROWS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_COLUMN_COUNT: column_count_q <= cfg_data[COLS_REG_BITS-1:0];
				CFG_ROW_COUNT:    row_count_q    <= cfg_data[ROWS_REG_BITS-1:0];
			endcase
		end
	end

	// zero means one, oversize saturates
	always_comb begin
		if (column_count_q == '0) begin
			cols_w = CW'(1);
		end else if (32'(column_count_q) > 32'(MAX_COLUMNS)) begin
			cols_w = CW'(MAX_COLUMNS);
		end else begin
			cols_w = CW'(column_count_q);
		end
		rows_w = (row_count_q == '0) ? ROWS_REG_BITS'(1) : row_count_q;
	end

	assign last_col_w  = (CW'(col_q) + CW'(1)) >= cols_w;
	assign last_row_w  = ({1'b0, row_q} + 17'd1) >= {1'b0, rows_w};
	assign status.emit = fill_q >= (FW'(cols_w) + FW'(1));
	assign pix_ext     = INW'(pixel_in);
	assign pix_v       = (command == CMD_FLUSH) ? '0 : pix_ext[PIXEL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			cur_q       <= '0;
			wcnt_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			fill_q      <= '0;
			prev_q      <= '0;
			cols_q      <= CW'(1);
			top_q       <= 1'b0;
			left_edge_q <= 1'b0;
			last_col_q  <= 1'b0;
			last_row_q  <= 1'b0;
			down_q      <= '0;
		end else if (cmd.accept) begin
			wp_q   <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			cur_q  <= wp_q;
			prev_q <= pix_v;
			if (wcnt_q != NW'(DEPTH)) begin
				wcnt_q <= wcnt_q + NW'(1);
			end
			if (!status.emit) begin
				fill_q <= fill_q + FW'(1);
			end else begin
				cols_q      <= cols_w;
				top_q       <= (row_q == '0);
				left_edge_q <= (col_q == '0);
				last_col_q  <= last_col_w;
				last_row_q  <= last_row_w;
				down_q      <= last_row_w ? '0 : prev_q;
				if (last_col_w) begin
					col_q <= '0;
					if (last_row_w) begin
						row_q  <= '0;
						fill_q <= '0;
					end else begin
						row_q <= row_q + 16'd1;
					end
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
		end
	end

	// distance back from the newest ring word
	always_comb begin
		case (cmd.rd_sel)
			NB_RIGHT:  rd_off = AW'(cols_q);
			NB_CENTRE: rd_off = AW'(cols_q) + AW'(1);
			NB_LEFT:   rd_off = AW'(cols_q) + AW'(2);
			NB_UP:     rd_off = AW'({cols_q, 1'b0}) + AW'(1);
			default:   rd_off = AW'(cols_q);
		endcase
		if (cur_q >= rd_off) begin
			rd_addr = cur_q - rd_off;
		end else begin
			rd_addr = AW'(AW1'(cur_q) + AW1'(DEPTH) - AW1'(rd_off));
		end
		// never-written words read as zero
		rd_ok = NW'(rd_off) < wcnt_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[wp_q] <= pix_v;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1  <= 1'b0;
			rd_ok_s1  <= 1'b0;
			rd_sel_s1 <= NB_RIGHT;
		end else begin
			rd_en_s1  <= cmd.rd_en;
			rd_ok_s1  <= rd_ok;
			rd_sel_s1 <= cmd.rd_sel;
		end
	end

	assign rd_val = rd_ok_s1 ? rd_data_s1 : '0;

	// frame border masks applied on capture
	always_ff @(posedge clk) begin
		if (rd_en_s1) begin
			case (rd_sel_s1)
				NB_RIGHT:  right_q  <= last_col_q ? '0 : rd_val;
				NB_CENTRE: centre_q <= rd_val;
				NB_LEFT:   left_q   <= left_edge_q ? '0 : rd_val;
				NB_UP:     up_q     <= top_q ? '0 : rd_val;
				default:   centre_q <= rd_val;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			sum_q <= SW'(up_q) + SW'(down_q) + SW'(left_q) + SW'(right_q);
			nz_q  <= {2'b00, up_q != '0} + {2'b00, down_q != '0}
				+ {2'b00, left_q != '0} + {2'b00, right_q != '0};
		end
	end

	// divide by 1..4 as multiply by scaled reciprocal
	always_comb begin
		case (nz_q)
			3'd1:    rcp_w = RCP1;
			3'd2:    rcp_w = RCP2;
			3'd3:    rcp_w = RCP3;
			3'd4:    rcp_w = RCP4;
			default: rcp_w = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PW'(sum_q) * PW'(rcp_w);
		end
	end

	assign quot_w  = prod_q[K +: PIXEL_BITS];
	assign res_w   = (centre_q != '0) ? centre_q : quot_w;
	assign res_ext = EXW'(res_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pixel_out    <= res_ext[FIELD_BITS-1:0];
			was_filled   <= (centre_q == '0);
			end_of_row   <= last_col_q;
			end_of_frame <= last_col_q && last_row_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || !out_stall;

	`ZCNAF_ASSERT_IMPLIES(a_load_into_free_reg, clk, arst_n, cmd.load_out, (!out_valid_q || !out_stall), "result loaded over an untaken item")
	`ZCNAF_ASSERT_IMPLIES(a_write_count_bound, clk, arst_n, 1'b1, (wcnt_q <= NW'(DEPTH)), "ring write count ran past depth")

endmodule

/* rtl/zero_cell_neighbor_average_fill.sv */
// Result order: a pixel's result leaves column_count+1 items after it.
// Throughput: 1 item/cycle while priming; a result item stalls input until its result loads.
// The single read port of the history ring sets the rate; each result needs 4 reads.
// Reset: counters clear, column_count=1024, row_count=1, output empty.
// The ring gets no clearing pass; a write counter makes unwritten words read as zero.
module zero_cell_neighbor_average_fill import zcnaf_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// config write port
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// input item channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [FIELD_BITS-1:0]     pixel_in,
	// result item channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [FIELD_BITS-1:0]     pixel_out,
	output logic                      was_filled,
	output logic                      end_of_row,
	output logic                      end_of_frame
);

	// controller drives commands, datapath reports whether the item
	// yields a result and whether the output register can take one
	zcnaf_cmd_t    cmd;
	zcnaf_status_t status;

	zcnaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// ring, counters, reciprocal divide and the output register
	zcnaf_dp #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.PIXEL_BITS  (PIXEL_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.pixel_in     (pixel_in),
		.cmd          (cmd),
		.status       (status),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.pixel_out    (pixel_out),
		.was_filled   (was_filled),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule
